>>> design/tclmb_pkg.sv
// shared types, command codes and led patterns for the two-color led mode blinker
package tclmb_pkg;

	localparam int LED_W    = 6;
	localparam int MODE_W   = 2;
	localparam int CMD_W    = 3;
	localparam int COUNT_W  = 8;
	localparam int CFG_IDX_W = 8;

	localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PAUSE  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SET    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_TOGGLE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd4;

	localparam logic [MODE_W-1:0] MODE_STEADY_GREEN = 2'd0;
	localparam logic [MODE_W-1:0] MODE_STEADY_RED   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REC_GREEN    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_REC_RED      = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_STEADY_PERIOD = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RECORD_PERIOD = 8'd1;

	localparam logic [COUNT_W-1:0] STEADY_PERIOD_RST = 8'h06;
	localparam logic [COUNT_W-1:0] RECORD_PERIOD_RST = 8'h03;

	localparam logic [LED_W-1:0] LED_GREEN_TRIO = 6'h07;
	localparam logic [LED_W-1:0] LED_RED_TRIO   = 6'h38;
	localparam logic [LED_W-1:0] LED_GREEN_BACK = 6'h04;
	localparam logic [LED_W-1:0] LED_RED_BACK   = 6'h20;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [COUNT_W-1:0] pause_length;
		logic [MODE_W-1:0]  mode_value;
	} item_t;

	typedef struct packed {
		logic [LED_W-1:0]  leds;
		logic [MODE_W-1:0] current_mode;
		logic              mode_matches;
		logic              paused;
	} result_t;

	typedef struct packed {
		logic [LED_W-1:0] clr;
		logic [LED_W-1:0] set;
	} led_pattern_t;

	// leds forced off and on when a mode is entered
	function automatic led_pattern_t mode_pattern(input logic [MODE_W-1:0] m);
		led_pattern_t p;
		case (m)
			MODE_STEADY_GREEN: begin
				p.clr = 6'h3A;
				p.set = 6'h01;
			end
			MODE_STEADY_RED: begin
				p.clr = 6'h17;
				p.set = 6'h08;
			end
			MODE_REC_GREEN: begin
				p.clr = 6'h3B;
				p.set = 6'h04;
			end
			default: begin
				p.clr = 6'h1F;
				p.set = 6'h20;
			end
		endcase
		return p;
	endfunction

endpackage

>>> design/tclmb_core.sv
// blinker state registers and the per-command update logic
module tclmb_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  tclmb_pkg::item_t         item,
	input  logic [7:0]               steady_period,
	input  logic [7:0]               record_period,
	output tclmb_pkg::result_t       result
);
	import tclmb_pkg::*;

	logic [MODE_W-1:0]  mode_q, mode_d;
	logic [COUNT_W-1:0] pause_q, pause_d;
	logic [COUNT_W-1:0] fast_q, fast_d;
	logic [COUNT_W-1:0] slow_q, slow_d;
	logic [LED_W-1:0]   led_q, led_d;

	logic               paused_now;
	logic [COUNT_W-1:0] fast_ld, slow_ld;
	logic [LED_W-1:0]   led_tick;
	logic               do_apply;
	logic [MODE_W-1:0]  apply_mode;
	led_pattern_t       pat;

	assign paused_now = (pause_q != '0);

	always_comb begin
		led_tick = led_q;
		fast_ld  = fast_q;
		slow_ld  = slow_q;
		if (fast_q == '0) begin
			fast_ld = steady_period;
			if (mode_q == MODE_STEADY_GREEN)
				led_tick = led_tick ^ LED_GREEN_TRIO;
			else if (mode_q == MODE_STEADY_RED)
				led_tick = led_tick ^ LED_RED_TRIO;
		end
		if (slow_q == '0) begin
			slow_ld = record_period;
			if (mode_q == MODE_REC_GREEN)
				led_tick = led_tick ^ LED_GREEN_BACK;
			else if (mode_q == MODE_REC_RED)
				led_tick = led_tick ^ LED_RED_BACK;
		end
	end

	always_comb begin
		do_apply   = 1'b0;
		apply_mode = item.mode_value;
		case (item.cmd)
			CMD_SET: begin
				do_apply = 1'b1;
			end
			CMD_TOGGLE: begin
				if (mode_q == MODE_STEADY_GREEN) begin
					do_apply   = 1'b1;
					apply_mode = MODE_STEADY_RED;
				end else if (mode_q == MODE_STEADY_RED) begin
					do_apply   = 1'b1;
					apply_mode = MODE_STEADY_GREEN;
				end
			end
			default: begin
				do_apply = 1'b0;
			end
		endcase
	end

	assign pat = mode_pattern(apply_mode);

	always_comb begin
		mode_d  = mode_q;
		pause_d = pause_q;
		fast_d  = fast_q;
		slow_d  = slow_q;
		led_d   = led_q;
		case (item.cmd)
			CMD_TICK: begin
				if (paused_now) begin
					pause_d = pause_q - 1'b1;
				end else begin
					fast_d = fast_ld - 1'b1;
					slow_d = slow_ld - 1'b1;
					led_d  = led_tick;
				end
			end
			CMD_PAUSE: begin
				pause_d = item.pause_length;
			end
			default: begin
				if (do_apply && !paused_now) begin
					led_d  = (led_q & ~pat.clr) | pat.set;
					mode_d = apply_mode;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_STEADY_GREEN;
			pause_q <= '0;
			fast_q  <= '0;
			slow_q  <= '0;
			led_q   <= '0;
		end else if (en) begin
			mode_q  <= mode_d;
			pause_q <= pause_d;
			fast_q  <= fast_d;
			slow_q  <= slow_d;
			led_q   <= led_d;
		end
	end

	assign result.leds         = led_d;
	assign result.current_mode = mode_d;
	assign result.mode_matches = (mode_d == item.mode_value);
	assign result.paused       = (pause_d != '0);

endmodule

>>> design/two_color_led_mode_blinker_unit.sv
// top level: input word register, configuration registers and result register
// a word moves from the input word register to the result register
// throughput: one word per cycle unless stalled; one state update per word
// result stall holds the result register and backs up into the input register
// reset clears all leds, green mode, counters to zero, periods to 6 and 3
module two_color_led_mode_blinker_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  tclmb_pkg::item_t          item,
	output logic                      result_valid,
	input  logic                      result_stall,
	output tclmb_pkg::result_t        result,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [7:0]                cfg_index,
	input  logic [7:0]                cfg_data
);
	import tclmb_pkg::*;

	logic             valid_s1;
	item_t            item_s1;
	logic             out_free;
	logic             advance;
	result_t          res_next;
	logic [COUNT_W-1:0] steady_q, record_q;

	assign out_free   = !result_valid || !result_stall;
	assign advance    = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steady_q <= STEADY_PERIOD_RST;
			record_q <= RECORD_PERIOD_RST;
		end else if (cfg_valid) begin
			if (cfg_index == REG_STEADY_PERIOD)
				steady_q <= cfg_data;
			else if (cfg_index == REG_RECORD_PERIOD)
				record_q <= cfg_data;
		end
	end

	// input word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall)
			item_s1 <= item;
	end

	tclmb_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (advance),
		.item          (item_s1),
		.steady_period (steady_q),
		.record_period (record_q),
		.result        (res_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_free) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			result <= res_next;
	end

endmodule
